/* rtl/command_frame_deframer_crc32_assert.svh */
// Assertion macros shared by the deframer RTL files.
`ifndef COMMAND_FRAME_DEFRAMER_CRC32_ASSERT_SVH
`define COMMAND_FRAME_DEFRAMER_CRC32_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CFD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled while reset is high.
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

/* rtl/cfdcrc_pkg.sv */
// Shared types, constants and the CRC-32 byte update for the frame deframer.
package cfdcrc_pkg;

  localparam int unsigned DEF_MAX_PAYLOAD = 4096;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned PIDX_W = 12;
  localparam int unsigned PIPE_W = 48;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned ADDR_W = 3;

  localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0] CRC_XOUT = 32'hFFFF_FFFF;

  // Frame end status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_START = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STAT_W-1:0] ST_TRUNC     = 3'd3;
  localparam logic [STAT_W-1:0] ST_CRC_BAD   = 3'd4;

  // Result kinds
  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  // Register word index
  localparam logic REG_START_CODE = 1'b0;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [PIDX_W-1:0]   payload_index;
    logic [STAT_W-1:0]   status;
    logic [BYTE_W-1:0]   version;
    logic [15:0]         command_id;
    logic [PIPE_W-1:0]   pipe_id;
    logic [BYTE_W-1:0]   sequence_number;
    logic [WORD_W-1:0]   data_size;
    logic [WORD_W-1:0]   received_crc;
    logic [WORD_W-1:0]   computed_crc;
  } res_t;

  // Reflected CRC-32, one byte, LSB first.
  function automatic logic [WORD_W-1:0] crc32_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/cfdcrc_parser.sv */
// Frame parser: header capture, payload count, running CRC and frame status.
`include "command_frame_deframer_crc32_assert.svh"

module cfdcrc_parser #(
  parameter int unsigned MAX_PAYLOAD = cfdcrc_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [cfdcrc_pkg::BYTE_W-1:0] in_byte,
  input  logic                         buffer_end,
  input  logic [cfdcrc_pkg::WORD_W-1:0] start_code,
  output logic                         res_valid,
  output cfdcrc_pkg::res_t             res
);

  localparam int unsigned CNT_W = (MAX_PAYLOAD < 2) ? 1 : $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [7:0] {
    PH_START = 8'b0000_0001,
    PH_VER   = 8'b0000_0010,
    PH_CMD   = 8'b0000_0100,
    PH_PIPE  = 8'b0000_1000,
    PH_SEQ   = 8'b0001_0000,
    PH_SIZE  = 8'b0010_0000,
    PH_DATA  = 8'b0100_0000,
    PH_CRC   = 8'b1000_0000
  } phase_t;

  phase_t                          phase, phase_next;
  logic                            discarding, discarding_next;
  logic [2:0]                      hdr_cnt, hdr_cnt_next;
  logic [CNT_W-1:0]                pay_cnt, pay_cnt_next;
  logic [CNT_W-1:0]                pay_inc;
  logic [cfdcrc_pkg::BYTE_W-1:0]   hdr_version, hdr_version_next;
  logic [15:0]                     hdr_command, hdr_command_next;
  logic [cfdcrc_pkg::PIPE_W-1:0]   hdr_pipe, hdr_pipe_next;
  logic [cfdcrc_pkg::BYTE_W-1:0]   hdr_sequence, hdr_sequence_next;
  logic [cfdcrc_pkg::WORD_W-1:0]   hdr_size, hdr_size_next;
  logic [cfdcrc_pkg::WORD_W-1:0]   crc_running, crc_running_next;
  logic [cfdcrc_pkg::WORD_W-1:0]   crc_field, crc_field_next;
  logic [cfdcrc_pkg::WORD_W-1:0]   start_match, start_match_next;
  logic [cfdcrc_pkg::WORD_W-1:0]   crc_upd;
  logic                            have_status;
  logic [cfdcrc_pkg::STAT_W-1:0]   status;
  logic                            have_payload;
  logic                            clear;

  assign crc_upd = cfdcrc_pkg::crc32_byte(crc_running, in_byte);
  assign pay_inc = pay_cnt + CNT_W'(1);

  always_comb begin
    phase_next        = phase;
    discarding_next   = discarding;
    hdr_cnt_next      = hdr_cnt;
    pay_cnt_next      = pay_cnt;
    hdr_version_next  = hdr_version;
    hdr_command_next  = hdr_command;
    hdr_pipe_next     = hdr_pipe;
    hdr_sequence_next = hdr_sequence;
    hdr_size_next     = hdr_size;
    crc_running_next  = crc_running;
    crc_field_next    = crc_field;
    start_match_next  = start_match;
    have_status       = 1'b0;
    status            = cfdcrc_pkg::ST_OK;
    have_payload      = 1'b0;
    clear             = 1'b0;

    if (discarding) begin
      clear = buffer_end;
    end else begin
      unique case (phase)
        PH_START: begin
          start_match_next[8*hdr_cnt[1:0] +: 8] = start_match[8*hdr_cnt[1:0] +: 8] | in_byte;
          crc_running_next = crc_upd;
          hdr_cnt_next     = hdr_cnt + 3'd1;
          if (hdr_cnt == 3'd3) begin
            if (start_match_next != start_code) begin
              have_status = 1'b1;
              status      = cfdcrc_pkg::ST_BAD_START;
            end else begin
              phase_next   = PH_VER;
              hdr_cnt_next = 3'd0;
            end
          end
        end
        PH_VER: begin
          hdr_version_next = in_byte;
          crc_running_next = crc_upd;
          phase_next       = PH_CMD;
          hdr_cnt_next     = 3'd0;
        end
        PH_CMD: begin
          hdr_command_next[8*hdr_cnt[0] +: 8] = hdr_command[8*hdr_cnt[0] +: 8] | in_byte;
          crc_running_next = crc_upd;
          hdr_cnt_next     = hdr_cnt + 3'd1;
          if (hdr_cnt == 3'd1) begin
            phase_next   = PH_PIPE;
            hdr_cnt_next = 3'd0;
          end
        end
        PH_PIPE: begin
          hdr_pipe_next[8*hdr_cnt +: 8] = hdr_pipe[8*hdr_cnt +: 8] | in_byte;
          crc_running_next = crc_upd;
          hdr_cnt_next     = hdr_cnt + 3'd1;
          if (hdr_cnt == 3'd5) begin
            phase_next   = PH_SEQ;
            hdr_cnt_next = 3'd0;
          end
        end
        PH_SEQ: begin
          hdr_sequence_next = in_byte;
          crc_running_next  = crc_upd;
          phase_next        = PH_SIZE;
          hdr_cnt_next      = 3'd0;
        end
        PH_SIZE: begin
          hdr_size_next[8*hdr_cnt[1:0] +: 8] = hdr_size[8*hdr_cnt[1:0] +: 8] | in_byte;
          crc_running_next = crc_upd;
          hdr_cnt_next     = hdr_cnt + 3'd1;
          if (hdr_cnt == 3'd3) begin
            hdr_cnt_next = 3'd0;
            if (hdr_size_next > cfdcrc_pkg::WORD_W'(MAX_PAYLOAD)) begin
              have_status = 1'b1;
              status      = cfdcrc_pkg::ST_TOO_LARGE;
            end else if (hdr_size_next == '0) begin
              phase_next = PH_CRC;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          crc_running_next = crc_upd;
          have_payload     = 1'b1;
          pay_cnt_next     = pay_inc;
          // size is at most MAX_PAYLOAD here, so its low bits hold it whole
          if (pay_inc == hdr_size[CNT_W-1:0]) begin
            phase_next   = PH_CRC;
            hdr_cnt_next = 3'd0;
          end
        end
        PH_CRC: begin
          crc_field_next[8*hdr_cnt[1:0] +: 8] = crc_field[8*hdr_cnt[1:0] +: 8] | in_byte;
          hdr_cnt_next = hdr_cnt + 3'd1;
          if (hdr_cnt == 3'd3) begin
            have_status = 1'b1;
            status = (crc_field_next == (crc_running ^ cfdcrc_pkg::CRC_XOUT)) ?
                     cfdcrc_pkg::ST_OK : cfdcrc_pkg::ST_CRC_BAD;
          end
        end
        default: begin
          phase_next = PH_START;
        end
      endcase

      if (!have_status && buffer_end) begin
        have_status = 1'b1;
        status      = cfdcrc_pkg::ST_TRUNC;
      end

      if (have_status) begin
        clear           = buffer_end;
        discarding_next = !buffer_end;
      end
    end
  end

  // Build the result word from the updated fields.
  always_comb begin
    res       = '0;
    res_valid = !discarding && (have_status || have_payload);
    if (have_status) begin
      res.kind            = cfdcrc_pkg::KIND_FRAME_END;
      res.status          = status;
      res.version         = hdr_version_next;
      res.command_id      = hdr_command_next;
      res.pipe_id         = hdr_pipe_next;
      res.sequence_number = hdr_sequence_next;
      res.data_size       = hdr_size_next;
      res.received_crc    = crc_field_next;
      res.computed_crc    = crc_running_next ^ cfdcrc_pkg::CRC_XOUT;
    end else begin
      res.kind          = cfdcrc_pkg::KIND_PAYLOAD;
      res.payload_byte  = in_byte;
      res.payload_index = cfdcrc_pkg::PIDX_W'(pay_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      discarding   <= 1'b0;
      hdr_cnt      <= '0;
      pay_cnt      <= '0;
      hdr_version  <= '0;
      hdr_command  <= '0;
      hdr_pipe     <= '0;
      hdr_sequence <= '0;
      hdr_size     <= '0;
      crc_running  <= cfdcrc_pkg::CRC_INIT;
      crc_field    <= '0;
      start_match  <= '0;
    end else if (advance) begin
      if (clear) begin
        phase        <= PH_START;
        discarding   <= 1'b0;
        hdr_cnt      <= '0;
        pay_cnt      <= '0;
        hdr_version  <= '0;
        hdr_command  <= '0;
        hdr_pipe     <= '0;
        hdr_sequence <= '0;
        hdr_size     <= '0;
        crc_running  <= cfdcrc_pkg::CRC_INIT;
        crc_field    <= '0;
        start_match  <= '0;
      end else begin
        phase        <= phase_next;
        discarding   <= discarding_next;
        hdr_cnt      <= hdr_cnt_next;
        pay_cnt      <= pay_cnt_next;
        hdr_version  <= hdr_version_next;
        hdr_command  <= hdr_command_next;
        hdr_pipe     <= hdr_pipe_next;
        hdr_sequence <= hdr_sequence_next;
        hdr_size     <= hdr_size_next;
        crc_running  <= crc_running_next;
        crc_field    <= crc_field_next;
        start_match  <= start_match_next;
      end
    end
  end

  `CFD_ASSERT_NEXT(a_end_clears, clk, rst, advance && buffer_end,
                   phase == PH_START && !discarding && crc_running == cfdcrc_pkg::CRC_INIT)
  `CFD_ASSERT_NEXT(a_frame_end_discards, clk, rst,
                   advance && res_valid && res.kind == cfdcrc_pkg::KIND_FRAME_END && !buffer_end,
                   discarding)
  `CFD_ASSERT_NOW(a_quiet_when_discarding, clk, rst, discarding, !res_valid)

endmodule

/* rtl/command_frame_deframer_crc32.sv */
// Top level of the command frame deframer with CRC-32 check.
//
// Takes a received buffer one byte word per cycle (in_valid/in_stall) with
// buffer_end on the last byte, and parses frames of the form: 4-byte start
// code, version, 16-bit command, 6-byte pipe id, sequence, 32-bit payload
// size, payload, CRC-32 (all little endian). Every payload byte is handed on
// as a kind=0 word with its index (modulo 4096); each frame gives one kind=1
// word with the header fields and a status (ok, bad start, size too large,
// truncated, CRC mismatch; the first failure in byte order wins). The CRC is
// the reflected CRC-32 over all bytes before the CRC field. Bytes after a
// frame end are dropped until buffer_end. Rate: one byte word per cycle
// while in_stall is low; the path from the parser state registers to the
// result register is the byte-wide CRC update plus field capture. in_stall
// rises only while the result register holds a word that the output side
// is stalling. The user must write start_code over the APB-style port at
// byte address 0 while the block is idle; the block does not enforce it.
`include "command_frame_deframer_crc32_assert.svh"

module command_frame_deframer_crc32 #(
  parameter int unsigned MAX_PAYLOAD = cfdcrc_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                           clk,
  input  logic                           rst,
  // byte input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cfdcrc_pkg::BYTE_W-1:0]  in_byte,
  input  logic                           buffer_end,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           kind,
  output logic [cfdcrc_pkg::BYTE_W-1:0]  payload_byte,
  output logic [cfdcrc_pkg::PIDX_W-1:0]  payload_index,
  output logic [cfdcrc_pkg::STAT_W-1:0]  status,
  output logic [cfdcrc_pkg::BYTE_W-1:0]  version,
  output logic [15:0]                    command_id,
  output logic [cfdcrc_pkg::PIPE_W-1:0]  pipe_id,
  output logic [cfdcrc_pkg::BYTE_W-1:0]  sequence_number,
  output logic [cfdcrc_pkg::WORD_W-1:0]  data_size,
  output logic [cfdcrc_pkg::WORD_W-1:0]  received_crc,
  output logic [cfdcrc_pkg::WORD_W-1:0]  computed_crc,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cfdcrc_pkg::ADDR_W-1:0]  paddr,
  input  logic [cfdcrc_pkg::WORD_W-1:0]  pwdata,
  output logic [cfdcrc_pkg::WORD_W-1:0]  prdata,
  output logic                           pready
);

  logic [cfdcrc_pkg::WORD_W-1:0] start_code;
  logic                          cfg_wr;
  logic                          accept;
  logic                          res_valid;
  cfdcrc_pkg::res_t              res_comb;
  cfdcrc_pkg::res_t              res_q;

  // Configuration: one word register, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == cfdcrc_pkg::REG_START_CODE) ? start_code : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code <= '0;
    end else if (cfg_wr && paddr[2] == cfdcrc_pkg::REG_START_CODE) begin
      start_code <= pwdata;
    end
  end

  // Take a byte whenever the result register is empty or draining.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  cfdcrc_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .advance    (accept),
    .in_byte    (in_byte),
    .buffer_end (buffer_end),
    .start_code (start_code),
    .res_valid  (res_valid),
    .res        (res_comb)
  );

  // Result register: load on a producing byte, drop when taken, hold when stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      res_q <= res_comb;
    end
  end

  assign kind            = res_q.kind;
  assign payload_byte    = res_q.payload_byte;
  assign payload_index   = res_q.payload_index;
  assign status          = res_q.status;
  assign version         = res_q.version;
  assign command_id      = res_q.command_id;
  assign pipe_id         = res_q.pipe_id;
  assign sequence_number = res_q.sequence_number;
  assign data_size       = res_q.data_size;
  assign received_crc    = res_q.received_crc;
  assign computed_crc    = res_q.computed_crc;

  `CFD_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && out_stall, out_valid && $stable(res_q))
  `CFD_ASSERT_NOW(a_status_range, clk, rst, out_valid && kind == cfdcrc_pkg::KIND_FRAME_END,
                  status <= cfdcrc_pkg::ST_CRC_BAD)
  `CFD_ASSERT_NOW(a_payload_clean, clk, rst, out_valid && kind == cfdcrc_pkg::KIND_PAYLOAD,
                  status == cfdcrc_pkg::ST_OK && data_size == '0 && computed_crc == '0)

endmodule

/* bench/command_frame_deframer_crc32_chk.sv */
// Bench package and result checker for the command frame deframer.
`timescale 1ns / 100ps

package cfd_bench_pkg;
  import cfdcrc_pkg::*;

  localparam logic [ADDR_W-1:0] START_CODE_ADDR = {REG_START_CODE, 2'b00};

  // Reflected CRC-32 update, one data bit at a time, LSB first.
  function automatic logic [WORD_W-1:0] crc_next(input logic [WORD_W-1:0] acc,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    logic fb;
    c = acc;
    for (int k = 0; k < BYTE_W; k++) begin
      fb = c[0] ^ b[k];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction
endpackage

module command_frame_deframer_crc32_chk (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [cfdcrc_pkg::BYTE_W-1:0]  in_byte,
  input  logic                           buffer_end,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           kind,
  input  logic [cfdcrc_pkg::BYTE_W-1:0]  payload_byte,
  input  logic [cfdcrc_pkg::PIDX_W-1:0]  payload_index,
  input  logic [cfdcrc_pkg::STAT_W-1:0]  status,
  input  logic [cfdcrc_pkg::BYTE_W-1:0]  version,
  input  logic [15:0]                    command_id,
  input  logic [cfdcrc_pkg::PIPE_W-1:0]  pipe_id,
  input  logic [cfdcrc_pkg::BYTE_W-1:0]  sequence_number,
  input  logic [cfdcrc_pkg::WORD_W-1:0]  data_size,
  input  logic [cfdcrc_pkg::WORD_W-1:0]  received_crc,
  input  logic [cfdcrc_pkg::WORD_W-1:0]  computed_crc,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cfdcrc_pkg::ADDR_W-1:0]  paddr,
  input  logic [cfdcrc_pkg::WORD_W-1:0]  pwdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             pending
);
  import cfdcrc_pkg::*;
  import cfd_bench_pkg::*;

  typedef enum logic [3:0] {
    AWAIT_START, GET_VERSION, GET_COMMAND, GET_PIPE,
    GET_SEQUENCE, GET_SIZE, GET_PAYLOAD, GET_CRC
  } parse_phase_t;

  parse_phase_t      ph;
  int unsigned       byte_cnt;
  logic [7:0]        hdr_version;
  logic [15:0]       hdr_command;
  logic [PIPE_W-1:0] hdr_pipe;
  logic [7:0]        hdr_sequence;
  logic [31:0]       hdr_size;
  logic [31:0]       crc_acc;
  logic [31:0]       crc_rx;
  logic [31:0]       start_seen;
  logic [31:0]       start_code;
  bit                dropping;
  res_t              due_words[$];
  int                errors = 0;

  function automatic void clear_frame();
    ph = AWAIT_START;
    byte_cnt = 0;
    hdr_version = '0;
    hdr_command = '0;
    hdr_pipe = '0;
    hdr_sequence = '0;
    hdr_size = '0;
    crc_acc = CRC_INIT;
    crc_rx = '0;
    start_seen = '0;
    dropping = 1'b0;
  endfunction

  // Advance the frame parse by one byte; queue the word it produces, if any.
  task automatic deframe_byte(input logic [7:0] b, input logic last);
    res_t r;
    logic [STAT_W-1:0] st;
    bit ended;
    bit is_payload;
    logic [PIDX_W-1:0] idx;
    r = '0;
    st = ST_OK;
    ended = 1'b0;
    is_payload = 1'b0;
    idx = '0;
    if (dropping) begin
      if (last) clear_frame();
    end else begin
      case (ph)
        AWAIT_START: begin
          start_seen[8*byte_cnt +: 8] = b;
          crc_acc = crc_next(crc_acc, b);
          byte_cnt++;
          if (byte_cnt == 4) begin
            if (start_seen != start_code) begin
              ended = 1'b1;
              st = ST_BAD_START;
            end else begin
              ph = GET_VERSION;
              byte_cnt = 0;
            end
          end
        end
        GET_VERSION: begin
          hdr_version = b;
          crc_acc = crc_next(crc_acc, b);
          ph = GET_COMMAND;
          byte_cnt = 0;
        end
        GET_COMMAND: begin
          hdr_command[8*byte_cnt +: 8] = b;
          crc_acc = crc_next(crc_acc, b);
          byte_cnt++;
          if (byte_cnt == 2) begin
            ph = GET_PIPE;
            byte_cnt = 0;
          end
        end
        GET_PIPE: begin
          hdr_pipe[8*byte_cnt +: 8] = b;
          crc_acc = crc_next(crc_acc, b);
          byte_cnt++;
          if (byte_cnt == 6) begin
            ph = GET_SEQUENCE;
            byte_cnt = 0;
          end
        end
        GET_SEQUENCE: begin
          hdr_sequence = b;
          crc_acc = crc_next(crc_acc, b);
          ph = GET_SIZE;
          byte_cnt = 0;
        end
        GET_SIZE: begin
          hdr_size[8*byte_cnt +: 8] = b;
          crc_acc = crc_next(crc_acc, b);
          byte_cnt++;
          if (byte_cnt == 4) begin
            byte_cnt = 0;
            if (hdr_size > DEF_MAX_PAYLOAD) begin
              ended = 1'b1;
              st = ST_TOO_LARGE;
            end else if (hdr_size == 0) begin
              ph = GET_CRC;
            end else begin
              ph = GET_PAYLOAD;
            end
          end
        end
        GET_PAYLOAD: begin
          crc_acc = crc_next(crc_acc, b);
          is_payload = 1'b1;
          idx = PIDX_W'(byte_cnt);
          byte_cnt++;
          if (byte_cnt >= hdr_size) begin
            ph = GET_CRC;
            byte_cnt = 0;
          end
        end
        default: begin
          crc_rx[8*byte_cnt +: 8] = b;
          byte_cnt++;
          if (byte_cnt == 4) begin
            ended = 1'b1;
            st = (crc_rx == (crc_acc ^ CRC_XOUT)) ? ST_OK : ST_CRC_BAD;
          end
        end
      endcase
      if (!ended && last) begin
        ended = 1'b1;
        st = ST_TRUNC;
      end
      if (ended) begin
        r.kind = KIND_FRAME_END;
        r.status = st;
        r.version = hdr_version;
        r.command_id = hdr_command;
        r.pipe_id = hdr_pipe;
        r.sequence_number = hdr_sequence;
        r.data_size = hdr_size;
        r.received_crc = crc_rx;
        r.computed_crc = crc_acc ^ CRC_XOUT;
        due_words.push_back(r);
        if (last) clear_frame();
        else dropping = 1'b1;
      end else if (is_payload) begin
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        r.payload_index = idx;
        due_words.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_word();
    res_t want;
    if (due_words.size() == 0) begin
      errors++;
      $display("%0t: unexpected word, expected none, actual kind %0b status %0d",
               $time, kind, status);
    end else begin
      want = due_words.pop_front();
      check_field("kind", 64'(want.kind), 64'(kind));
      check_field("payload_byte", 64'(want.payload_byte), 64'(payload_byte));
      check_field("payload_index", 64'(want.payload_index), 64'(payload_index));
      check_field("status", 64'(want.status), 64'(status));
      check_field("version", 64'(want.version), 64'(version));
      check_field("command_id", 64'(want.command_id), 64'(command_id));
      check_field("pipe_id", 64'(want.pipe_id), 64'(pipe_id));
      check_field("sequence_number", 64'(want.sequence_number), 64'(sequence_number));
      check_field("data_size", 64'(want.data_size), 64'(data_size));
      check_field("received_crc", 64'(want.received_crc), 64'(received_crc));
      check_field("computed_crc", 64'(want.computed_crc), 64'(computed_crc));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start_code = '0;
      clear_frame();
      due_words.delete();
    end else begin
      if (out_valid && !out_stall) compare_word();
      if (psel && penable && pwrite && pready && paddr == START_CODE_ADDR)
        start_code = pwdata;
      if (in_valid && !in_stall) deframe_byte(in_byte, buffer_end);
    end
    pending <= due_words.size();
    fail_count <= errors;
  end
endmodule

/* bench/command_frame_deframer_crc32_tb.sv */
// Testbench top for the command frame deframer: stimulus, idling and verdict.
`timescale 1ns / 100ps

module command_frame_deframer_crc32_tb;
  import cfdcrc_pkg::*;
  import cfd_bench_pkg::*;

  // Cycles to let the last byte clear the pipe before a register write.
  localparam int DRAIN = 4;
  // Random bytes to send after the directed frames.
  localparam int RANDOM_BYTES = 320;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_byte = '0;
  logic                 buffer_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 kind;
  logic [BYTE_W-1:0]    payload_byte;
  logic [PIDX_W-1:0]    payload_index;
  logic [STAT_W-1:0]    status;
  logic [BYTE_W-1:0]    version;
  logic [15:0]          command_id;
  logic [PIPE_W-1:0]    pipe_id;
  logic [BYTE_W-1:0]    sequence_number;
  logic [WORD_W-1:0]    data_size;
  logic [WORD_W-1:0]    received_crc;
  logic [WORD_W-1:0]    computed_crc;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [WORD_W-1:0]    pwdata = '0;
  logic [WORD_W-1:0]    prdata;
  logic                 pready;
  int                   fail_count;
  int                   pending;

  // Buffer under construction, sent front to back with buffer_end on the last byte.
  logic [7:0]           frame_q[$];
  // Start code the block currently holds.
  logic [31:0]          cur_code = '0;
  // Sender gaps on or off for the current buffer.
  bit                   idle_in = 1'b1;
  // Receiver stalls on or off; changed with nonblocking writes only.
  bit                   stall_out_on = 1'b1;
  int                   stall_left = 0;

  command_frame_deframer_crc32 dut (.*);
  command_frame_deframer_crc32_chk watch (.*);

  always #4 clk = ~clk;

  // Receiver: after each accepted word, stall for a random number of cycles.
  // The next word may show up anywhere inside that window, so stalls land on
  // every phase of the parse.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      stall_left = stall_out_on ? $urandom_range(0, 10) : 0;
      out_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  // Offer one byte word; hold it until the block takes it. Valid drops only
  // when a gap is drawn, so back-to-back words keep it high.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_in ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    buffer_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_buffer();
    foreach (frame_q[k]) send_byte(frame_q[k], k == frame_q.size() - 1);
  endtask

  // Append a value little endian, low byte first.
  task automatic push_le(input logic [63:0] v, input int n);
    for (int k = 0; k < n; k++) frame_q.push_back(v[8*k +: 8]);
  endtask

  // Build a frame with random header content. The size field and the number
  // of payload bytes are given apart so that oversize frames can carry a tail.
  task automatic build_frame(input logic [31:0] sc, input logic [31:0] size_field,
                             input int n_payload, input bit corrupt);
    logic [31:0] c;
    logic [47:0] pipe;
    frame_q.delete();
    pipe = {16'($urandom), 32'($urandom)};
    push_le(64'(sc), 4);
    push_le(64'($urandom_range(0, 255)), 1);
    push_le(64'($urandom_range(0, 65535)), 2);
    push_le(64'(pipe), 6);
    push_le(64'($urandom_range(0, 255)), 1);
    push_le(64'(size_field), 4);
    repeat (n_payload) frame_q.push_back(8'($urandom));
    c = CRC_INIT;
    foreach (frame_q[k]) c = crc_next(c, frame_q[k]);
    c = c ^ CRC_XOUT;
    // Flip one bit to force a CRC mismatch.
    if (corrupt) c = c ^ (32'h1 << $urandom_range(0, 31));
    push_le(64'(c), 4);
  endtask

  task automatic cut_to(input int n);
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endtask

  task automatic add_junk(input int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  // Drop valid and hold until every predicted word has come out.
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write start_code only with the block idle: drained, plus a DRAIN wait for
  // a last byte that makes no word.
  task automatic set_start_code(input logic [31:0] v);
    wait_results();
    repeat (DRAIN) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= START_CODE_ADDR;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_code = v;
  endtask

  // One random buffer: mostly well-formed frames with random content, the
  // rest broken in every way the parser reports, plus plain noise.
  task automatic random_buffer();
    int pick;
    int size;
    pick = $urandom_range(0, 99);
    size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 200) : $urandom_range(0, 12);
    if (pick < 10) begin
      frame_q.delete();
      add_junk($urandom_range(1, 10));
    end else if (pick < 18) begin
      build_frame(cur_code ^ (32'h1 << $urandom_range(0, 31)), size, size, 1'b0);
    end else if (pick < 25) begin
      build_frame(cur_code,
                  $urandom_range(0, 1) ? $urandom_range(4097, 70000) : {1'b1, 31'($urandom)},
                  $urandom_range(0, 4), 1'b0);
    end else if (pick < 33) begin
      build_frame(cur_code, size, size, 1'b1);
    end else if (pick < 45) begin
      build_frame(cur_code, size, size, 1'b0);
      cut_to($urandom_range(1, frame_q.size() - 1));
    end else begin
      build_frame(cur_code, size, size, 1'b0);
    end
    // Bytes after a finished frame must be dropped up to buffer_end.
    if (pick >= 10 && $urandom_range(0, 4) == 0) add_junk($urandom_range(1, 4));
  endtask

  initial begin
    int ph;
    int sent;
    logic [31:0] codes[4];
    codes = '{32'($urandom), 32'h0, 32'($urandom), 32'hFFFF_FFFF};
    sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Buffer that ends on its first start byte: truncated right away.
    frame_q.delete();
    frame_q.push_back(8'h00);
    send_buffer();
    // Zero-size frame against the start code left by reset.
    build_frame(cur_code, 0, 0, 1'b0);
    send_buffer();

    set_start_code(32'hFFFF_FFFF);
    // Good frame followed by bytes to drop.
    build_frame(cur_code, 3, 3, 1'b0);
    add_junk(2);
    send_buffer();
    // Start code wrong in its second byte.
    build_frame(cur_code ^ 32'h0000_0100, 2, 2, 1'b0);
    send_buffer();
    // Wrong start code on the buffer's last byte: bad start wins over truncation.
    build_frame(cur_code ^ 32'h8000_0000, 0, 0, 1'b0);
    cut_to(4);
    send_buffer();
    // One byte over the size limit, with a tail to drop.
    build_frame(cur_code, DEF_MAX_PAYLOAD + 1, 3, 1'b0);
    send_buffer();
    // Oversize detected on the last byte of the buffer.
    build_frame(cur_code, 32'hFFFF_FFFF, 0, 1'b0);
    cut_to(18);
    send_buffer();
    // Buffer ends on a payload byte: that byte gives no payload word.
    build_frame(cur_code, 5, 5, 1'b0);
    cut_to(20);
    send_buffer();
    // Buffer ends inside the CRC field.
    build_frame(cur_code, 5, 5, 1'b0);
    cut_to(25);
    send_buffer();
    // Buffer ends inside the command field.
    build_frame(cur_code, 1, 1, 1'b0);
    cut_to(7);
    send_buffer();
    // CRC mismatch.
    build_frame(cur_code, 4, 4, 1'b1);
    send_buffer();

    // Size exactly at the limit is taken; the buffer then ends on the sixth
    // payload byte. Sent without idling for back-to-back words.
    idle_in = 1'b0;
    stall_out_on <= 1'b0;
    build_frame(cur_code, DEF_MAX_PAYLOAD, 6, 1'b0);
    cut_to(24);
    send_buffer();
    wait_results();

    // Random part, split over several start codes including both extremes.
    for (ph = 0; ph < 4; ph++) begin
      set_start_code(codes[ph]);
      while (sent < RANDOM_BYTES * (ph + 1) / 4) begin
        idle_in = ($urandom_range(0, 3) != 0);
        stall_out_on <= ($urandom_range(0, 3) != 0);
        random_buffer();
        send_buffer();
        sent += frame_q.size();
        // Now and then let the output side drain completely.
        if ($urandom_range(0, 9) == 0) wait_results();
      end
    end

    wait_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end
endmodule
